>>> design/bounded_unique_value_set_macros.svh
// ---------------------------------------------------------------------------
// Bounded unique value set: assertion macros
// Shared assertion forms for the checker of the bounded unique value set.
// ---------------------------------------------------------------------------
`ifndef BOUNDED_UNIQUE_VALUE_SET_MACROS_SVH
`define BOUNDED_UNIQUE_VALUE_SET_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BVS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BVS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/bvs_pkg.sv
// ---------------------------------------------------------------------------
// Bounded unique value set: package
// Sizes, status codes and the command and status groups between the
// controller and the datapath.
// ---------------------------------------------------------------------------
package bvs_pkg;

	localparam int MAX_ENTRIES = 32;
	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = 6;
	localparam int VAL_W = 32;
	localparam int ST_W = 3;

	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(20);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

	localparam logic KIND_ADD = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	localparam logic [ST_W-1:0] ST_ADDED = 3'd0;
	localparam logic [ST_W-1:0] ST_PRESENT = 3'd1;
	localparam logic [ST_W-1:0] ST_FULL = 3'd2;
	localparam logic [ST_W-1:0] ST_REMOVED = 3'd3;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd4;
	localparam logic [ST_W-1:0] ST_EMPTY = 3'd5;

	typedef struct packed {
		logic load_item;
		logic scan_init;
		logic scan_run;
		logic shift_wr;
		logic append;
		logic dec_count;
		logic set_res;
		logic [ST_W-1:0] res_code;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic kind;
		logic full;
		logic empty;
		logic hit;
		logic scan_end;
		logic data_vld;
	} dp_stat_t;

endpackage

>>> design/bounded_unique_value_set.sv
// ---------------------------------------------------------------------------
// Bounded unique value set
// Set of distinct 32-bit signed values in insertion order, with a
// configurable capacity, add and remove requests and one result per item.
// ---------------------------------------------------------------------------
// One item is worked on at a time. The entry memory has one read port, so the
// search reads one entry per cycle and stops at the first match. A removal
// then moves each later entry down one slot per cycle. Full and empty errors
// are found in the check state, before any search. The result waits in an
// output register, and the next item is accepted the cycle after the result
// is loaded there, even while it waits. The capacity register may be written
// at any time the block is idle; values above 32 act as 32.
module bounded_unique_value_set (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            kind,
	input  logic signed [bvs_pkg::VAL_W-1:0] value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [bvs_pkg::ST_W-1:0]        status,
	output logic [bvs_pkg::CNT_W-1:0]       entry_total,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bvs_pkg::CNT_W-1:0]       cfg_data
);

	bvs_pkg::dp_cmd_t  cmd;
	bvs_pkg::dp_stat_t stat;

	assign cfg_ready = 1'b1;

	bvs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bvs_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.kind       (kind),
		.value      (value),
		.status     (status),
		.entry_total(entry_total)
	);

endmodule

>>> design/bvs_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ---------------------------------------------------------------------------
module bvs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> design/bvs_ctrl.sv
// ---------------------------------------------------------------------------
// Bounded unique value set: controller
// Sequences one request through check, scan, shift and response.
// ---------------------------------------------------------------------------
module bvs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  bvs_pkg::dp_stat_t stat,
	output bvs_pkg::dp_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_RESP = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.kind == bvs_pkg::KIND_ADD && stat.full) begin
					cmd.set_res = 1'b1;
					cmd.res_code = bvs_pkg::ST_FULL;
					state_d = S_RESP;
				end else if (stat.kind == bvs_pkg::KIND_REMOVE && stat.empty) begin
					cmd.set_res = 1'b1;
					cmd.res_code = bvs_pkg::ST_EMPTY;
					state_d = S_RESP;
				end else begin
					cmd.scan_init = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (stat.hit) begin
					if (stat.kind == bvs_pkg::KIND_ADD) begin
						cmd.set_res = 1'b1;
						cmd.res_code = bvs_pkg::ST_PRESENT;
						state_d = S_RESP;
					end else begin
						state_d = S_SHIFT;
					end
				end else if (stat.scan_end) begin
					cmd.set_res = 1'b1;
					if (stat.kind == bvs_pkg::KIND_ADD) begin
						cmd.append = 1'b1;
						cmd.res_code = bvs_pkg::ST_ADDED;
					end else begin
						cmd.res_code = bvs_pkg::ST_NOT_FOUND;
					end
					state_d = S_RESP;
				end
			end
			S_SHIFT: begin
				cmd.scan_run = 1'b1;
				cmd.shift_wr = 1'b1;
				if (!stat.data_vld) begin
					cmd.dec_count = 1'b1;
					cmd.set_res = 1'b1;
					cmd.res_code = bvs_pkg::ST_REMOVED;
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> design/bvs_dp.sv
// ---------------------------------------------------------------------------
// Bounded unique value set: datapath
// Entry memory, count, capacity, scan pointer and result registers.
// ---------------------------------------------------------------------------
module bvs_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bvs_pkg::dp_cmd_t                cmd,
	output bvs_pkg::dp_stat_t               stat,
	input  logic                            cfg_valid,
	input  logic [bvs_pkg::CNT_W-1:0]       cfg_data,
	input  logic                            kind,
	input  logic signed [bvs_pkg::VAL_W-1:0] value,
	output logic [bvs_pkg::ST_W-1:0]        status,
	output logic [bvs_pkg::CNT_W-1:0]       entry_total
);

	logic [bvs_pkg::CNT_W-1:0]       cap_q;
	logic [bvs_pkg::CNT_W-1:0]       count_q;
	logic                            kind_q;
	logic signed [bvs_pkg::VAL_W-1:0] value_q;
	logic [bvs_pkg::CNT_W-1:0]       rd_ptr_q;
	logic                            dvld_q;
	logic [bvs_pkg::ST_W-1:0]        res_q;
	logic [bvs_pkg::ST_W-1:0]        status_q;
	logic [bvs_pkg::CNT_W-1:0]       total_q;

	logic [bvs_pkg::CNT_W-1:0] eff_cap;
	logic [bvs_pkg::CNT_W-1:0] shift_addr;
	logic                      rd_en;
	logic                      wr_en;
	logic [bvs_pkg::IDX_W-1:0] wr_addr;
	logic [bvs_pkg::VAL_W-1:0] wr_data;
	logic [bvs_pkg::VAL_W-1:0] rd_data;

	assign eff_cap = (cap_q > bvs_pkg::MAX_CNT) ? bvs_pkg::MAX_CNT : cap_q;
	assign rd_en = cmd.scan_run && (rd_ptr_q < count_q);
	assign shift_addr = rd_ptr_q - bvs_pkg::CNT_W'(2);

	assign wr_en = cmd.append || (cmd.shift_wr && dvld_q);
	assign wr_addr = cmd.append ? count_q[bvs_pkg::IDX_W-1:0]
		: shift_addr[bvs_pkg::IDX_W-1:0];
	assign wr_data = cmd.append ? $unsigned(value_q) : rd_data;

	bvs_ram #(
		.WIDTH(bvs_pkg::VAL_W),
		.DEPTH(bvs_pkg::MAX_ENTRIES)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_ptr_q[bvs_pkg::IDX_W-1:0]),
		.rd_data(rd_data)
	);

	assign stat.kind = kind_q;
	assign stat.full = (count_q >= eff_cap);
	assign stat.empty = (count_q == '0);
	assign stat.hit = dvld_q && (rd_data == $unsigned(value_q));
	assign stat.scan_end = (rd_ptr_q == count_q);
	assign stat.data_vld = dvld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= bvs_pkg::CAP_RESET;
			count_q <= '0;
			rd_ptr_q <= '0;
			dvld_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			if (cmd.append) begin
				count_q <= count_q + bvs_pkg::CNT_W'(1);
			end else if (cmd.dec_count) begin
				count_q <= count_q - bvs_pkg::CNT_W'(1);
			end
			if (cmd.scan_init) begin
				rd_ptr_q <= '0;
				dvld_q <= 1'b0;
			end else if (cmd.scan_run) begin
				if (rd_en) begin
					rd_ptr_q <= rd_ptr_q + bvs_pkg::CNT_W'(1);
				end
				dvld_q <= rd_en;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q <= kind;
			value_q <= value;
		end
		if (cmd.set_res) begin
			res_q <= cmd.res_code;
		end
		if (cmd.load_out) begin
			status_q <= res_q;
			total_q <= count_q;
		end
	end

	assign status = status_q;
	assign entry_total = total_q;

endmodule

>>> design/bvs_chk.sv
// ---------------------------------------------------------------------------
// Bounded unique value set: port checker
// Checks results seen on the ports of the bounded unique value set.
// ---------------------------------------------------------------------------
`include "bounded_unique_value_set_macros.svh"

module bvs_chk (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [bvs_pkg::ST_W-1:0]  status,
	input logic [bvs_pkg::CNT_W-1:0] entry_total
);

	logic out_stall;
	logic out_added;

	assign out_stall = out_valid && !out_ready;
	assign out_added = out_valid && (status == bvs_pkg::ST_ADDED);

	`BVS_ASSERT_NOW(a_status_code, out_valid, status <= bvs_pkg::ST_EMPTY, "bad status code")
	`BVS_ASSERT_NOW(a_total_range, out_valid, entry_total <= bvs_pkg::MAX_CNT, "count too high")
	`BVS_ASSERT_NOW(a_added_total, out_added, entry_total != '0, "added with zero count")
	`BVS_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable({status, entry_total}), "item changed")

endmodule

bind bounded_unique_value_set bvs_chk u_chk (.*);

>>> sim/bvs_tb_pkg.sv
// ---------------------------------------------------------------------------
// Bounded unique value set: scoreboard
// Mirror of the stored set and the capacity register, the results that
// each accepted request should produce, and their in-order comparison
// with the results that the block returns.
// ---------------------------------------------------------------------------
package bvs_tb_pkg;

	import bvs_pkg::*;

	typedef struct {
		logic [ST_W-1:0]  status;
		logic [CNT_W-1:0] total;
	} set_outcome_t;

	class set_scoreboard;
		logic signed [VAL_W-1:0] mirror_values[$];
		logic [CNT_W-1:0]        capacity;
		set_outcome_t            awaited_results[$];
		int                      requests;
		int                      results;
		int                      mismatches;
		int                      deepest_fill;
		int                      status_hits[6];

		function new();
			capacity = CAP_RESET;
			requests = 0;
			results = 0;
			mismatches = 0;
			deepest_fill = 0;
			foreach (status_hits[i]) status_hits[i] = 0;
		endfunction

		function void set_capacity(logic [CNT_W-1:0] cap);
			capacity = cap;
		endfunction

		function int pending();
			return awaited_results.size();
		endfunction

		function void note_request(logic req_kind, logic signed [VAL_W-1:0] req_value);
			set_outcome_t     outcome;
			logic [CNT_W-1:0] room;
			int               pos;
			room = (capacity > MAX_CNT) ? MAX_CNT : capacity;
			pos = -1;
			foreach (mirror_values[i])
				if (pos < 0 && mirror_values[i] == req_value) pos = i;
			if (req_kind == KIND_ADD) begin
				if (mirror_values.size() >= room) begin
					outcome.status = ST_FULL;
				end else if (pos >= 0) begin
					outcome.status = ST_PRESENT;
				end else begin
					mirror_values.push_back(req_value);
					outcome.status = ST_ADDED;
				end
			end else if (mirror_values.size() == 0) begin
				outcome.status = ST_EMPTY;
			end else if (pos < 0) begin
				outcome.status = ST_NOT_FOUND;
			end else begin
				mirror_values.delete(pos);
				outcome.status = ST_REMOVED;
			end
			outcome.total = CNT_W'(mirror_values.size());
			if (mirror_values.size() > deepest_fill) deepest_fill = mirror_values.size();
			status_hits[int'(outcome.status)]++;
			requests++;
			awaited_results.push_back(outcome);
		endfunction

		function void check_result(logic [ST_W-1:0] status, logic [CNT_W-1:0] total);
			set_outcome_t outcome;
			results++;
			if (awaited_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: status %0d, total %0d", status, total);
			end else begin
				outcome = awaited_results.pop_front();
				if (status !== outcome.status || total !== outcome.total) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Result %0d: expected status %0d total %0d, got status %0d total %0d",
							results, outcome.status, outcome.total, status, total);
				end
			end
		endfunction
	endclass

endpackage

>>> sim/tb_top.sv
// ---------------------------------------------------------------------------
// Bounded unique value set: testbench
// Drives add and remove requests through a directed opening and random
// phases at several capacity settings, with bursty input and stalls on the
// result side, and checks every result against the scoreboard mirror.
// ---------------------------------------------------------------------------
module tb_top;

	import bvs_pkg::*;
	import bvs_tb_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int LONG_HOLD = 400;
	localparam int PHASE_ITEMS = 115;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic                    req_kind;
	logic signed [VAL_W-1:0] req_value;
	logic                    out_valid;
	logic                    out_ready;
	logic [ST_W-1:0]         status;
	logic [CNT_W-1:0]        entry_total;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CNT_W-1:0]        cfg_data;

	set_scoreboard sb;
	bit            stall_request = 1'b0;
	int            cycle_count = 0;
	int            settings_written = 0;

	bounded_unique_value_set dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (req_kind),
		.value      (req_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.entry_total(entry_total),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(status, entry_total);
	end

	initial begin
		int          hold_left;
		int          stretch_left;
		int          mode;
		int          bit_pos;
		logic [31:0] pattern;
		hold_left = 0;
		stretch_left = 0;
		mode = 0;
		bit_pos = 0;
		pattern = '1;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_request) begin
				stall_request = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (stretch_left == 0) begin
					stretch_left = $urandom_range(16, 96);
					mode = $urandom_range(0, 2);
					pattern = $urandom | 32'h1;
					bit_pos = 0;
				end
				stretch_left--;
				case (mode)
					0: out_ready <= 1'b1;
					1: begin
						out_ready <= pattern[bit_pos];
						bit_pos = (bit_pos + 1) % 32;
					end
					default: out_ready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	task automatic send_request(input logic k, input logic signed [VAL_W-1:0] v);
		in_valid <= 1'b1;
		req_kind <= k;
		req_value <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(k, v);
	endtask

	task automatic pause(input int cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [CNT_W-1:0] cap);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= cap;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_capacity(cap);
		settings_written++;
		cfg_valid <= 1'b0;
	endtask

	task automatic run_directed();
		send_request(KIND_REMOVE, 32'sd0);
		send_request(KIND_ADD, 32'sh80000000);
		send_request(KIND_ADD, 32'sh7fffffff);
		send_request(KIND_ADD, 32'sd0);
		send_request(KIND_ADD, -32'sd1);
		send_request(KIND_ADD, 32'sh80000000);
		send_request(KIND_REMOVE, 32'sd5);
		send_request(KIND_REMOVE, 32'sh80000000);
		send_request(KIND_REMOVE, 32'sd0);
		send_request(KIND_REMOVE, -32'sd1);
		send_request(KIND_ADD, 32'sh55555555);
		send_request(KIND_ADD, 32'shaaaaaaaa);
		// Capacity below the current count keeps the entries and blocks adds.
		set_capacity(CNT_W'(2));
		send_request(KIND_ADD, 32'sd7);
		send_request(KIND_ADD, 32'sh55555555);
		send_request(KIND_REMOVE, 32'sh55555555);
		send_request(KIND_ADD, 32'sd7);
		send_request(KIND_REMOVE, 32'sh7fffffff);
		send_request(KIND_ADD, 32'sd7);
		set_capacity(CNT_W'(0));
		send_request(KIND_ADD, 32'sd9);
		send_request(KIND_REMOVE, 32'sd7);
		send_request(KIND_REMOVE, 32'shaaaaaaaa);
		send_request(KIND_REMOVE, 32'sd1);
		set_capacity(CNT_W'(1));
		send_request(KIND_ADD, 32'sd3);
		send_request(KIND_ADD, 32'sd3);
		send_request(KIND_REMOVE, 32'sd3);
	endtask

	task automatic run_phase(input logic [CNT_W-1:0] cap, input int items,
			input bit long_hold, input bit mid_pause);
		logic signed [VAL_W-1:0] pool [48];
		int                      pool_span;
		int                      burst_left;
		int                      rush_left;
		int                      add_pct;
		logic                    k;
		logic signed [VAL_W-1:0] v;
		foreach (pool[i]) pool[i] = $urandom;
		pool[0] = 32'sh80000000;
		pool[1] = 32'sh7fffffff;
		pool[2] = 32'sd0;
		pool[3] = -32'sd1;
		pool_span = (cap >= MAX_CNT) ? 48 : $urandom_range(6, 48);
		burst_left = 0;
		rush_left = 0;
		set_capacity(cap);
		for (int i = 0; i < items; i++) begin
			if (long_hold && i == 0) begin
				stall_request = 1'b1;
				rush_left = 48;
			end
			if (mid_pause && i == items / 2) drain();
			add_pct = (i < items / 2) ? 75 : 35;
			k = ($urandom_range(0, 99) < add_pct) ? KIND_ADD : KIND_REMOVE;
			v = ($urandom_range(0, 9) < 8) ? pool[$urandom_range(0, pool_span - 1)] : $urandom;
			send_request(k, v);
			if (rush_left > 0) begin
				rush_left--;
			end else begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 16);
					pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
				end
				burst_left--;
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		req_kind <= KIND_ADD;
		req_value <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_phase(CNT_W'(32), PHASE_ITEMS, 1'b0, 1'b0);
		run_phase(CNT_W'(63), PHASE_ITEMS, 1'b1, 1'b0);
		run_phase(CNT_W'(1), PHASE_ITEMS, 1'b0, 1'b0);
		run_phase(CNT_W'(5), PHASE_ITEMS, 1'b0, 1'b1);
		run_phase(CNT_W'(0), PHASE_ITEMS, 1'b0, 1'b0);
		run_phase(CNT_W'(33), PHASE_ITEMS, 1'b0, 1'b0);
		run_phase(CNT_W'($urandom_range(1, 32)), PHASE_ITEMS, 1'b0, 1'b0);
		run_phase(CAP_RESET, PHASE_ITEMS, 1'b0, 1'b0);
		drain();
		repeat (MAX_ENTRIES + 8) @(posedge clk);
		if (sb.pending() != 0) $display("%0d expected results never arrived", sb.pending());
		$display("Ran %0d requests over %0d capacity settings, deepest fill %0d entries.",
			sb.requests, settings_written, sb.deepest_fill);
		$display("Statuses: added %0d, present %0d, full %0d,",
			sb.status_hits[ST_ADDED], sb.status_hits[ST_PRESENT], sb.status_hits[ST_FULL]);
		$display("  removed %0d, not found %0d, empty %0d.",
			sb.status_hits[ST_REMOVED], sb.status_hits[ST_NOT_FOUND],
			sb.status_hits[ST_EMPTY]);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+design
design/bvs_pkg.sv
design/bvs_ram.sv
design/bvs_ctrl.sv
design/bvs_dp.sv
design/bounded_unique_value_set.sv
design/bvs_chk.sv
sim/bvs_tb_pkg.sv
sim/tb_top.sv
